/* rtl/rpn_pkg.sv */
// Shared types, codes and constants for the RPN stack calculator.
package rpn_pkg;

	localparam int StackDepth = 128;
	localparam int SpW = $clog2(StackDepth + 1);
	localparam int AddrW = $clog2(StackDepth);
	localparam int QueueDepth = 2;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MOD  = 3'd5,
		OP_PRT  = 3'd6,
		OP_UNK  = 3'd7
	} op_t;

	// one classified word between front and back
	typedef struct packed {
		op_t         op;
		logic [31:0] value;
		logic [1:0]  npop;
	} cmd_t;

	typedef struct packed {
		logic        print_valid;
		logic [31:0] printed_value;
		logic [1:0]  underflow_count;
		logic        overflow_flag;
		logic        zero_divisor_flag;
		logic        unknown_flag;
		logic        saturated_flag;
	} res_t;

	localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] QMin = 32'sh8000_0000;

endpackage

/* rtl/rpn_front.sv */
// Front end: accept tokens, classify them and queue them for the back end.
module rpn_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [2:0]      op,
	input  logic [31:0]     operand_value,
	output logic            cmd_valid,
	input  logic            cmd_take,
	output rpn_pkg::cmd_t   cmd
);

	localparam int PtrW = $clog2(rpn_pkg::QueueDepth);

	rpn_pkg::cmd_t        fifo_q [rpn_pkg::QueueDepth];
	logic [PtrW-1:0]      wr_q, rd_q;
	logic [PtrW:0]        cnt_q;
	rpn_pkg::cmd_t        cls;
	logic                 wr_en, rd_en;

	always_comb begin
		cls.op = rpn_pkg::op_t'(op);
		cls.value = operand_value;
		unique case (rpn_pkg::op_t'(op))
			rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
			rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: cls.npop = 2'd2;
			rpn_pkg::OP_PRT: cls.npop = 2'd1;
			default: cls.npop = 2'd0;
		endcase
	end

	assign full = cnt_q == (PtrW+1)'(rpn_pkg::QueueDepth);
	assign wr_en = push && !full;
	assign cmd_valid = cnt_q != '0;
	assign rd_en = cmd_valid && cmd_take;
	assign cmd = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
		end
	end

endmodule

/* rtl/rpn_div.sv */
// Iterative restoring divider on magnitudes, one quotient bit a cycle.
module rpn_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [47:0] quotient,
	output logic [31:0] remainder
);

	logic [47:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [33:0] trial;

	assign shifted = {rem_q, quo_q[47]};
	assign trial = {1'b0, shifted} - {2'b0, dsr_q};
	assign quotient = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// the partial remainder stays below the divisor, so 32 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

endmodule

/* rtl/rpn_back.sv */
// Back end: stack memory, operand pops, arithmetic and the result register.
module rpn_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_take,
	input  rpn_pkg::cmd_t   cmd,
	output logic            res_valid,
	input  logic            res_take,
	output rpn_pkg::res_t   res
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RD_B  = 9'b000000010,
		ST_GET_B = 9'b000000100,
		ST_RD_A  = 9'b000001000,
		ST_GET_A = 9'b000010000,
		ST_MUL   = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_WAIT  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [31:0] mem [rpn_pkg::StackDepth];
	logic [31:0] rd_data_q;
	logic [rpn_pkg::SpW-1:0] sp_q;
	rpn_pkg::op_t op_q;
	logic [31:0] a_q, b_q;
	logic [1:0]  uf_q;
	logic signed [63:0] prod_q;
	logic        neg_q;
	rpn_pkg::res_t out_q;
	logic        outv_q;

	logic mem_we;
	logic [rpn_pkg::AddrW-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;

	logic        div_start, div_done;
	logic [47:0] div_dvd, div_quo;
	logic [31:0] div_dsr, div_rem;

	logic sp_empty;
	assign sp_empty = sp_q == '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	assign mem_ra = rpn_pkg::AddrW'(sp_q - 1'b1);

	rpn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dsr), .done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	function automatic logic [31:0] iabs(input logic [31:0] v);
		return v[31] ? (~v + 1'b1) : v;
	endfunction

	// integer part truncated toward zero, as a 16-bit signed value
	function automatic logic signed [15:0] itrunc(input logic [31:0] v);
		logic [31:0] m;
		logic [15:0] ip;
		m = iabs(v);
		ip = m[31:16];
		return v[31] ? 16'(~ip + 1'b1) : ip;
	endfunction

	logic signed [15:0] a_int, b_int;
	assign a_int = itrunc(a_q);
	assign b_int = itrunc(b_q);

	// operands for the divider
	always_comb begin
		if (op_q == rpn_pkg::OP_MOD) begin
			div_dvd = {32'd0, 16'(a_int[15] ? -a_int : a_int)};
			div_dsr = {16'd0, 16'(b_int[15] ? -b_int : b_int)};
		end else begin
			div_dvd = {iabs(a_q), 16'd0};
			div_dsr = iabs(b_q);
		end
	end

	logic need_b, need_a;
	logic zero_div;
	assign zero_div = (op_q == rpn_pkg::OP_DIV && b_q == '0) ||
		(op_q == rpn_pkg::OP_MOD && b_int == '0);

	// final arithmetic result, clamped to the signed 32-bit range
	logic signed [33:0] sum;
	logic signed [49:0] wide;
	logic signed [31:0] result;
	logic sat;
	logic [48:0] qmag;
	logic [16:0] rmag;

	always_comb begin
		sum = '0;
		wide = '0;
		qmag = {1'b0, div_quo};
		rmag = {1'b0, div_rem[15:0]};
		case (op_q)
			rpn_pkg::OP_ADD: sum = 34'(signed'(a_q)) + 34'(signed'(b_q));
			rpn_pkg::OP_SUB: sum = 34'(signed'(a_q)) - 34'(signed'(b_q));
			default: sum = '0;
		endcase
		case (op_q)
			rpn_pkg::OP_MUL: wide = 50'(prod_q >>> 16);
			rpn_pkg::OP_DIV: wide = neg_q ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
			rpn_pkg::OP_MOD: wide = neg_q ? -50'(signed'({1'b0, rmag})) <<< 16
				: 50'(signed'({1'b0, rmag})) <<< 16;
			default: wide = 50'(sum);
		endcase
		sat = 1'b0;
		if (wide > 50'(rpn_pkg::QMax)) begin
			result = rpn_pkg::QMax;
			sat = 1'b1;
		end else if (wide < 50'(rpn_pkg::QMin)) begin
			result = rpn_pkg::QMin;
			sat = 1'b1;
		end else begin
			result = wide[31:0];
		end
	end

	assign need_b = op_q != rpn_pkg::OP_PUSH && op_q != rpn_pkg::OP_UNK;
	assign need_a = need_b && op_q != rpn_pkg::OP_PRT;

	assign cmd_take = state_q == ST_IDLE && cmd_valid && !outv_q;
	assign res_valid = outv_q;
	assign res = out_q;
	// start once the left operand has landed in a_q
	assign div_start = state_q == ST_WAIT;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = rpn_pkg::AddrW'(sp_q);
		mem_wd = result;
		if (cmd_take && cmd.op == rpn_pkg::OP_PUSH &&
				sp_q < rpn_pkg::SpW'(rpn_pkg::StackDepth)) begin
			mem_we = 1'b1;
			mem_wd = cmd.value;
		end else if (state_q == ST_DONE && !zero_div &&
				sp_q < rpn_pkg::SpW'(rpn_pkg::StackDepth)) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q <= '0;
			outv_q <= 1'b0;
			uf_q <= '0;
		end else begin
			if (outv_q && res_take) begin
				outv_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						uf_q <= '0;
						if (cmd.op == rpn_pkg::OP_PUSH) begin
							outv_q <= 1'b1;
							if (sp_q < rpn_pkg::SpW'(rpn_pkg::StackDepth)) begin
								sp_q <= sp_q + 1'b1;
							end
						end else if (cmd.op == rpn_pkg::OP_UNK) begin
							outv_q <= 1'b1;
						end else begin
							state_q <= ST_RD_B;
						end
					end
				end
				ST_RD_B: state_q <= ST_GET_B;
				ST_GET_B: begin
					if (sp_empty) begin
						uf_q <= uf_q + 1'b1;
					end else begin
						sp_q <= sp_q - 1'b1;
					end
					state_q <= need_a ? ST_RD_A : ST_DONE;
				end
				ST_RD_A: begin
					// a zero divisor leaves the left operand alone
					state_q <= zero_div ? ST_DONE : ST_GET_A;
				end
				ST_GET_A: begin
					if (sp_empty) begin
						uf_q <= uf_q + 1'b1;
					end else begin
						sp_q <= sp_q - 1'b1;
					end
					if (op_q == rpn_pkg::OP_MUL) begin
						state_q <= ST_MUL;
					end else if (op_q == rpn_pkg::OP_DIV || op_q == rpn_pkg::OP_MOD) begin
						state_q <= ST_WAIT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL: state_q <= ST_DONE;
				ST_WAIT: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (need_a && !zero_div &&
							sp_q < rpn_pkg::SpW'(rpn_pkg::StackDepth)) begin
						sp_q <= sp_q + 1'b1;
					end
					outv_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_q <= cmd.op;
			a_q <= '0;
			b_q <= '0;
			out_q <= '{
				print_valid: 1'b0,
				printed_value: '0,
				underflow_count: '0,
				overflow_flag: cmd.op == rpn_pkg::OP_PUSH &&
					sp_q >= rpn_pkg::SpW'(rpn_pkg::StackDepth),
				zero_divisor_flag: 1'b0,
				unknown_flag: cmd.op == rpn_pkg::OP_UNK,
				saturated_flag: 1'b0
			};
		end
		if (state_q == ST_GET_B && !sp_empty) begin
			b_q <= rd_data_q;
		end
		if (state_q == ST_GET_A && !sp_empty) begin
			a_q <= rd_data_q;
		end
		if (state_q == ST_MUL) begin
			prod_q <= signed'(a_q) * signed'(b_q);
		end
		if (state_q == ST_GET_A) begin
			neg_q <= (op_q == rpn_pkg::OP_MOD) ? itrunc(sp_empty ? a_q : rd_data_q) < 0
				: (sp_empty ? a_q[31] : rd_data_q[31]) ^ b_q[31];
		end
		if (state_q == ST_DONE) begin
			out_q.underflow_count <= uf_q;
			if (op_q == rpn_pkg::OP_PRT) begin
				out_q.print_valid <= 1'b1;
				out_q.printed_value <= b_q;
			end else if (zero_div) begin
				out_q.zero_divisor_flag <= 1'b1;
			end else begin
				out_q.saturated_flag <= sat;
				out_q.overflow_flag <= sp_q >= rpn_pkg::SpW'(rpn_pkg::StackDepth);
			end
		end
	end

endmodule

/* rtl/rpn_stack_calculator_unit.sv */
// Top level of the RPN stack calculator.
// Tokens enter through a two-word queue and are carried out one at a time by
// the back end. Push and unknown tokens go from idle straight to the result
// word; print pops one operand, add and sub pop two, mul adds a multiply step,
// and div and mod run the restoring divider, which yields one quotient bit a
// cycle over a 48-bit dividend; a zero divisor ends div and mod before the
// second pop and the divider. The next token starts only once the result word
// has been popped.
// Stack entries are read only below the stack pointer, so the store needs no
// clearing after reset.
module rpn_stack_calculator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic signed [31:0] operand_value,
	output logic        empty,
	input  logic        pop,
	output logic        print_valid,
	output logic signed [31:0] printed_value,
	output logic [1:0]  underflow_count,
	output logic        overflow_flag,
	output logic        zero_divisor_flag,
	output logic        unknown_flag,
	output logic        saturated_flag
);

	rpn_pkg::cmd_t cmd;
	rpn_pkg::res_t res;
	logic cmd_valid, cmd_take, res_valid;

	rpn_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op),
		.operand_value(operand_value), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .cmd(cmd)
	);

	rpn_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .res_valid(res_valid), .res_take(pop), .res(res)
	);

	assign empty = !res_valid;
	assign print_valid = res.print_valid;
	assign printed_value = res.printed_value;
	assign underflow_count = res.underflow_count;
	assign overflow_flag = res.overflow_flag;
	assign zero_divisor_flag = res.zero_divisor_flag;
	assign unknown_flag = res.unknown_flag;
	assign saturated_flag = res.saturated_flag;

endmodule
